// ===== rtl/core/mbpi_pkg.sv =====
// ----------------------------------------------------------------------------
// mbpi_pkg
// shared types, constants and the cordic angle table of the pose integrator
// ----------------------------------------------------------------------------
package mbpi_pkg;

  typedef enum logic [1:0] {
    DM_DIFF     = 2'd0,
    DM_OMNI     = 2'd1,
    DM_OMNI_ROT = 2'd2,
    DM_ACKER    = 2'd3
  } drive_model_e;

  typedef enum logic [2:0] {
    RI_MODEL   = 3'd0,
    RI_STEP    = 3'd1,
    RI_WBASE   = 3'd2,
    RI_START_X = 3'd3,
    RI_START_Y = 3'd4,
    RI_START_H = 3'd5
  } reg_idx_e;

  // round(2^32 / (2*pi)) in q0.32
  localparam logic [63:0] INV_TWO_PI = 64'd683565276;

  localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
  localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;
  localparam logic signed [33:0] HALF_TURN    = 34'sd2147483648;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [31:0] angle;
  } cor_req_t;

  typedef struct packed {
    logic        done;
    logic [33:0] cos_v;
    logic [33:0] sin_v;
  } cor_rsp_t;

  // atan(2^-i) as a binary angle, 2^32 per turn
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/mbpi_cmd_if.sv =====
// ----------------------------------------------------------------------------
// mbpi_cmd_if
// velocity command channel, valid/ready
// ----------------------------------------------------------------------------
interface mbpi_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] first_cmd;
  logic signed [31:0] second_cmd;
  logic signed [31:0] third_cmd;

  modport source (output valid, output first_cmd, output second_cmd, output third_cmd,
                  input ready);
  modport sink   (input valid, input first_cmd, input second_cmd, input third_cmd,
                  output ready);
endinterface

// ===== rtl/core/mbpi_pose_if.sv =====
// ----------------------------------------------------------------------------
// mbpi_pose_if
// pose result channel, valid/ready
// ----------------------------------------------------------------------------
interface mbpi_pose_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pose_x_out;
  logic signed [31:0] pose_y_out;
  logic        [31:0] heading_out;
  logic               saturated;

  modport source (output valid, output pose_x_out, output pose_y_out, output heading_out,
                  output saturated, input ready);
  modport sink   (input valid, input pose_x_out, input pose_y_out, input heading_out,
                  input saturated, output ready);
endinterface

// ===== rtl/core/mbpi_cordic.sv =====
// ----------------------------------------------------------------------------
// mbpi_cordic
// rotation-mode cordic on binary angles, one micro-rotation per cycle
// ----------------------------------------------------------------------------
module mbpi_cordic import mbpi_pkg::*; #(
  parameter int ITERATIONS = 24
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cor_req_t req_i,
  output cor_rsp_t rsp_o
);

  localparam logic [4:0] LAST = 5'(ITERATIONS - 1);

  logic              busy_q, done_q, flip_q;
  logic [4:0]        cnt_q;
  logic signed [33:0] x_q, y_q, a_q;
  logic signed [33:0] a0, a_init, xs, ys, atan_s;
  logic              flip_init;

  always_comb begin
    a0        = 34'($signed(req_i.angle));
    a_init    = a0;
    flip_init = 1'b0;
    if (a0 > QUARTER_TURN) begin
      a_init    = a0 - HALF_TURN;
      flip_init = 1'b1;
    end else if (a0 < -QUARTER_TURN) begin
      a_init    = a0 + HALF_TURN;
      flip_init = 1'b1;
    end
    atan_s = $signed({2'b00, atan_turn(cnt_q)});
    xs     = x_q >>> cnt_q;
    ys     = y_q >>> cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q    <= CORDIC_GAIN;
      y_q    <= '0;
      a_q    <= a_init;
      flip_q <= flip_init;
    end else if (busy_q) begin
      if (!a_q[33]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        a_q <= a_q - atan_s;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        a_q <= a_q + atan_s;
      end
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.cos_v = flip_q ? -x_q : x_q;
  assign rsp_o.sin_v = flip_q ? -y_q : y_q;

endmodule

// ===== rtl/core/mbpi_mul.sv =====
// ----------------------------------------------------------------------------
// mbpi_mul
// shift-add multiplier, low 64 bits of the product, one bit per cycle
// ----------------------------------------------------------------------------
module mbpi_mul import mbpi_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  logic        busy_q, done_q;
  logic [63:0] acc_q, a_q, b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && (b_q == '0)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // stops as soon as no multiplier bits are left
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0;
      a_q   <= req_i.a;
      b_q   <= req_i.b;
    end else if (busy_q && (b_q != '0)) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= {a_q[62:0], 1'b0};
      b_q <= {1'b0, b_q[63:1]};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.p    = acc_q;

endmodule

// ===== rtl/core/mbpi_div.sv =====
// ----------------------------------------------------------------------------
// mbpi_div
// signed restoring divider, quotient truncated toward zero, one bit per cycle
// ----------------------------------------------------------------------------
module mbpi_div import mbpi_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic        busy_q, done_q, neg_q;
  logic [5:0]  cnt_q;
  logic [63:0] rem_q, quo_q, den_q;
  logic [64:0] shifted, diff;

  assign shifted = {rem_q, quo_q[63]};
  assign diff    = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.num[63] ^ req_i.den[63];
      rem_q <= '0;
      quo_q <= req_i.num[63] ? (64'd0 - req_i.num) : req_i.num;
      den_q <= req_i.den[63] ? (64'd0 - req_i.den) : req_i.den;
    end else if (busy_q) begin
      if (!diff[64]) begin
        rem_q <= diff[63:0];
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= shifted[63:0];
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = neg_q ? (64'd0 - quo_q) : quo_q;

endmodule

// ===== rtl/core/mobile_base_pose_integrator.sv =====
// ----------------------------------------------------------------------------
// mobile_base_pose_integrator
// planar pose integration for differential, omni and ackermann drive bases
// ----------------------------------------------------------------------------
// One command request is taken while the block is idle and yields one pose
// result. The work runs under a small sequencer on three shared units: a
// cordic, a shift-add multiplier that stops once no bits of its second
// operand are left, and a restoring divider. Omni drive is one cordic and
// six multiplies, omni drive with turn rate adds two multiplies, the exact
// arc is a divide, two cordics and four multiplies, and ackermann adds two
// multiplies, a cordic and two divides in front of the arc. A finished pose
// sits in an output register, so the next request is taken while it waits.
// Writing start_x, start_y or start_heading also loads the current pose.
module mobile_base_pose_integrator import mbpi_pkg::*; #(
  parameter int CORDIC_ITERATIONS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  mbpi_cmd_if.sink    cmd_i,
  mbpi_pose_if.source pose_o
);

  typedef enum logic [21:0] {
    ST_IDLE  = 22'h000001,
    ST_BSC   = 22'h000002,
    ST_BM1   = 22'h000004,
    ST_BM2   = 22'h000008,
    ST_BM3   = 22'h000010,
    ST_BM4   = 22'h000020,
    ST_BM5   = 22'h000040,
    ST_BM6   = 22'h000080,
    ST_TM1   = 22'h000100,
    ST_TM2   = 22'h000200,
    ST_ACHK  = 22'h000400,
    ST_ADIV  = 22'h000800,
    ST_ASC0  = 22'h001000,
    ST_ASC1  = 22'h002000,
    ST_AM1   = 22'h004000,
    ST_AM2   = 22'h008000,
    ST_KMUL  = 22'h010000,
    ST_KSC   = 22'h020000,
    ST_KDIV  = 22'h040000,
    ST_KM2   = 22'h080000,
    ST_KDIV2 = 22'h100000,
    ST_DONE  = 22'h200000
  } state_e;

  typedef struct packed {
    logic        clip;
    logic [31:0] val;
  } sat_t;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  function automatic sat_t sat32(input logic signed [63:0] v);
    sat_t r;
    r.clip = 1'b0;
    r.val  = v[31:0];
    if (v > S32_MAX) begin
      r.clip = 1'b1;
      r.val  = 32'h7fffffff;
    end else if (v < S32_MIN) begin
      r.clip = 1'b1;
      r.val  = 32'h80000000;
    end
    return r;
  endfunction

  // configuration
  logic [1:0]  mode_q;
  logic [16:0] ts_q;
  logic [30:0] wb_q;
  logic [31:0] sx_q, sy_q, sh_q;

  // pose state
  logic signed [31:0] x_q, y_q;
  logic [31:0]        head_q;
  logic               clip_q;

  // sequencer and scratch
  state_e             state_q, state_d;
  logic               iss_q, iss_d;
  logic               spin_q;
  logic signed [31:0] vx_q, vy_q, om_q, r_q;
  logic [31:0]        h1_q;
  logic signed [33:0] c0_q, s0_q, c1_q, s1_q;
  logic signed [63:0] t1_q;

  // output register
  logic               out_valid_q;
  logic signed [31:0] ox_q, oy_q;
  logic [31:0]        oh_q;
  logic               osat_q;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;
  cor_req_t cor_req;
  cor_rsp_t cor_rsp;

  logic signed [63:0] mul_p, div_q, ts64, len64;
  logic signed [33:0] cor_c, cor_s;
  logic               cfg_we, accept;
  logic [31:0]        turn;
  sat_t               x_lin, y_lin, x_arc, y_arc, q_sat;

  assign cfg_we  = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign accept  = cmd_i.valid & cmd_i.ready;
  assign cmd_i.ready = (state_q == ST_IDLE);

  assign mul_p = $signed(mul_rsp.p);
  assign div_q = $signed(div_rsp.quo);
  assign cor_c = $signed(cor_rsp.cos_v);
  assign cor_s = $signed(cor_rsp.sin_v);
  assign ts64  = $signed({47'd0, ts_q});
  // zero wheelbase counts as one lsb
  assign len64 = (wb_q == '0) ? 64'sd1 : $signed({33'd0, wb_q});
  assign turn  = mul_rsp.p[63:32];

  assign x_lin = sat32(64'(x_q) + (mul_p >>> 16));
  assign y_lin = sat32(64'(y_q) + (mul_p >>> 16));
  assign x_arc = sat32(64'(x_q) + (mul_p >>> 30));
  assign y_arc = sat32(64'(y_q) + (mul_p >>> 30));
  assign q_sat = sat32(div_q);

  mbpi_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
    .clk_i, .rst_ni, .req_i(cor_req), .rsp_o(cor_rsp)
  );

  mbpi_mul u_mul (
    .clk_i, .rst_ni, .req_i(mul_req), .rsp_o(mul_rsp)
  );

  mbpi_div u_div (
    .clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp)
  );

  // sequencer: each unit step issues once, then waits for the unit to finish
  always_comb begin
    state_d = state_q;
    mul_req = '0;
    div_req = '0;
    cor_req = '0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_i.valid) begin
          case (mode_q)
            DM_DIFF:     state_d = ST_ACHK;
            DM_OMNI:     state_d = ST_BSC;
            DM_OMNI_ROT: state_d = ST_BSC;
            default:     state_d = (cmd_i.second_cmd == '0) ? ST_BSC : ST_KMUL;
          endcase
        end
      end
      ST_BSC: begin
        cor_req.start = !iss_q;
        cor_req.angle = head_q;
        if (cor_rsp.done) state_d = ST_BM1;
      end
      ST_BM1: begin
        mul_req.start = !iss_q;
        mul_req.a     = 64'(vx_q);
        mul_req.b     = 64'(c0_q);
        if (mul_rsp.done) state_d = ST_BM2;
      end
      ST_BM2: begin
        mul_req.start = !iss_q;
        mul_req.a     = 64'(vy_q);
        mul_req.b     = 64'(s0_q);
        if (mul_rsp.done) state_d = ST_BM3;
      end
      ST_BM3: begin
        mul_req.start = !iss_q;
        mul_req.a     = t1_q;
        mul_req.b     = ts64;
        if (mul_rsp.done) state_d = ST_BM4;
      end
      ST_BM4: begin
        mul_req.start = !iss_q;
        mul_req.a     = 64'(vx_q);
        mul_req.b     = 64'(s0_q);
        if (mul_rsp.done) state_d = ST_BM5;
      end
      ST_BM5: begin
        mul_req.start = !iss_q;
        mul_req.a     = 64'(vy_q);
        mul_req.b     = 64'(c0_q);
        if (mul_rsp.done) state_d = ST_BM6;
      end
      ST_BM6: begin
        mul_req.start = !iss_q;
        mul_req.a     = t1_q;
        mul_req.b     = ts64;
        if (mul_rsp.done) state_d = spin_q ? ST_TM1 : ST_DONE;
      end
      ST_TM1: begin
        mul_req.start = !iss_q;
        mul_req.a     = 64'(om_q);
        mul_req.b     = ts64;
        if (mul_rsp.done) state_d = ST_TM2;
      end
      ST_TM2: begin
        mul_req.start = !iss_q;
        mul_req.a     = t1_q;
        mul_req.b     = INV_TWO_PI;
        if (mul_rsp.done) state_d = spin_q ? ST_DONE : ST_ASC0;
      end
      ST_ACHK: begin
        state_d = (om_q == '0) ? ST_BSC : ST_ADIV;
      end
      ST_ADIV: begin
        div_req.start = !iss_q;
        div_req.num   = 64'(vx_q) <<< 16;
        div_req.den   = 64'(om_q);
        if (div_rsp.done) state_d = ST_TM1;
      end
      ST_ASC0: begin
        cor_req.start = !iss_q;
        cor_req.angle = head_q;
        if (cor_rsp.done) state_d = ST_ASC1;
      end
      ST_ASC1: begin
        cor_req.start = !iss_q;
        cor_req.angle = h1_q;
        if (cor_rsp.done) state_d = ST_AM1;
      end
      ST_AM1: begin
        mul_req.start = !iss_q;
        mul_req.a     = 64'(r_q);
        mul_req.b     = 64'(s1_q) - 64'(s0_q);
        if (mul_rsp.done) state_d = ST_AM2;
      end
      ST_AM2: begin
        mul_req.start = !iss_q;
        mul_req.a     = 64'(r_q);
        mul_req.b     = 64'(c0_q) - 64'(c1_q);
        if (mul_rsp.done) state_d = ST_DONE;
      end
      ST_KMUL: begin
        mul_req.start = !iss_q;
        mul_req.a     = 64'(om_q);
        mul_req.b     = INV_TWO_PI;
        if (mul_rsp.done) state_d = ST_KSC;
      end
      ST_KSC: begin
        cor_req.start = !iss_q;
        cor_req.angle = h1_q;
        if (cor_rsp.done) state_d = ST_KDIV;
      end
      ST_KDIV: begin
        // zero cosine: tangent is the extreme with the sign of the sine
        if (c0_q == '0) begin
          state_d = ST_KM2;
        end else begin
          div_req.start = !iss_q;
          div_req.num   = 64'(s0_q) <<< 16;
          div_req.den   = 64'(c0_q);
          if (div_rsp.done) state_d = ST_KM2;
        end
      end
      ST_KM2: begin
        mul_req.start = !iss_q;
        mul_req.a     = 64'(vx_q);
        mul_req.b     = 64'(r_q);
        if (mul_rsp.done) state_d = ST_KDIV2;
      end
      ST_KDIV2: begin
        div_req.start = !iss_q;
        div_req.num   = t1_q;
        div_req.den   = len64;
        if (div_rsp.done) state_d = ST_ACHK;
      end
      ST_DONE: begin
        if (!out_valid_q || pose_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    iss_d = (iss_q | mul_req.start | div_req.start | cor_req.start)
            & ~(mul_rsp.done | div_rsp.done | cor_rsp.done);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      iss_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      iss_q   <= iss_d;
    end
  end

  // configuration and pose state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= DM_DIFF;
      ts_q   <= 17'd655;
      wb_q   <= 31'd32768;
      sx_q   <= '0;
      sy_q   <= '0;
      sh_q   <= '0;
      x_q    <= '0;
      y_q    <= '0;
      head_q <= '0;
      clip_q <= 1'b0;
    end else if (cfg_we) begin
      case (paddr[4:2])
        RI_MODEL: mode_q <= pwdata[1:0];
        RI_STEP:  ts_q   <= pwdata[16:0];
        RI_WBASE: wb_q   <= pwdata[30:0];
        RI_START_X: begin
          sx_q <= pwdata;
          x_q  <= pwdata;
        end
        RI_START_Y: begin
          sy_q <= pwdata;
          y_q  <= pwdata;
        end
        RI_START_H: begin
          sh_q   <= pwdata;
          head_q <= pwdata;
        end
        default: ;
      endcase
    end else begin
      if (accept) clip_q <= 1'b0;
      case (state_q)
        ST_BM3: if (mul_rsp.done) begin
          x_q    <= x_lin.val;
          clip_q <= clip_q | x_lin.clip;
        end
        ST_BM6: if (mul_rsp.done) begin
          y_q    <= y_lin.val;
          clip_q <= clip_q | y_lin.clip;
        end
        ST_TM2: if (mul_rsp.done && spin_q) head_q <= head_q + turn;
        ST_ADIV: if (div_rsp.done) clip_q <= clip_q | q_sat.clip;
        ST_AM1: if (mul_rsp.done) begin
          x_q    <= x_arc.val;
          clip_q <= clip_q | x_arc.clip;
        end
        ST_AM2: if (mul_rsp.done) begin
          y_q    <= y_arc.val;
          clip_q <= clip_q | y_arc.clip;
          head_q <= h1_q;
        end
        default: ;
      endcase
    end
  end

  // scratch registers of the sequencer
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: if (accept) begin
        vx_q   <= cmd_i.first_cmd;
        vy_q   <= (mode_q == DM_OMNI || mode_q == DM_OMNI_ROT) ? cmd_i.second_cmd : '0;
        om_q   <= (mode_q == DM_OMNI_ROT) ? cmd_i.third_cmd : cmd_i.second_cmd;
        spin_q <= (mode_q == DM_OMNI_ROT);
      end
      ST_BSC: if (cor_rsp.done) begin
        c0_q <= cor_c;
        s0_q <= cor_s;
      end
      ST_BM1: if (mul_rsp.done) t1_q <= mul_p;
      ST_BM2: if (mul_rsp.done) t1_q <= (t1_q - mul_p) >>> 30;
      ST_BM4: if (mul_rsp.done) t1_q <= mul_p;
      ST_BM5: if (mul_rsp.done) t1_q <= (t1_q + mul_p) >>> 30;
      ST_TM1: if (mul_rsp.done) t1_q <= mul_p;
      ST_TM2: if (mul_rsp.done) h1_q <= head_q + turn;
      ST_ADIV: if (div_rsp.done) r_q <= q_sat.val;
      ST_ASC0: if (cor_rsp.done) begin
        c0_q <= cor_c;
        s0_q <= cor_s;
      end
      ST_ASC1: if (cor_rsp.done) begin
        c1_q <= cor_c;
        s1_q <= cor_s;
      end
      ST_KMUL: if (mul_rsp.done) h1_q <= mul_rsp.p[47:16];
      ST_KSC: if (cor_rsp.done) begin
        c0_q <= cor_c;
        s0_q <= cor_s;
      end
      ST_KDIV: begin
        if (c0_q == '0) begin
          r_q <= s0_q[33] ? 32'h80000000 : 32'h7fffffff;
        end else if (div_rsp.done) begin
          r_q <= q_sat.val;
        end
      end
      ST_KM2: if (mul_rsp.done) t1_q <= mul_p;
      ST_KDIV2: if (div_rsp.done) om_q <= q_sat.val;
      default: ;
    endcase
  end

  // output register, loaded when the previous pose has been taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && (!out_valid_q || pose_o.ready)) begin
      out_valid_q <= 1'b1;
    end else if (pose_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && (!out_valid_q || pose_o.ready)) begin
      ox_q   <= x_q;
      oy_q   <= y_q;
      oh_q   <= head_q;
      osat_q <= clip_q;
    end
  end

  assign pose_o.valid       = out_valid_q;
  assign pose_o.pose_x_out  = ox_q;
  assign pose_o.pose_y_out  = oy_q;
  assign pose_o.heading_out = oh_q;
  assign pose_o.saturated   = osat_q;

  // register read back
  always_comb begin
    case (paddr[4:2])
      RI_MODEL:   prdata = {30'd0, mode_q};
      RI_STEP:    prdata = {15'd0, ts_q};
      RI_WBASE:   prdata = {1'd0, wb_q};
      RI_START_X: prdata = sx_q;
      RI_START_Y: prdata = sy_q;
      RI_START_H: prdata = sh_q;
      default:    prdata = '0;
    endcase
  end

  // no shared unit finishes while the sequencer is idle
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !(mul_rsp.done || div_rsp.done || cor_rsp.done))
    else $error("shared unit finished while idle");

  // one unit request at a time
  a_one_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({mul_req.start, div_req.start, cor_req.start}))
    else $error("more than one unit request");

  // a new pose only comes out of the done step
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("pose presented outside done step");

endmodule

// ===== verif/mbpi_pose_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mbpi_pose_checker
// follows register writes and command requests, forecasts every new pose and
// compares it with the pose channel
// ----------------------------------------------------------------------------
module mbpi_pose_checker import mbpi_pkg::*; #(
  parameter int CORDIC_ITERATIONS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  mbpi_cmd_if         cmd,
  mbpi_pose_if        pose,
  output int          errors_o,
  output int          pending_o
);

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] h;
    logic        sat;
  } pose_t;

  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;

  drive_model_e model_q;
  logic [16:0]  step_q;
  logic [30:0]  wbase_q;
  logic [31:0]  px_q, py_q, ph_q;
  bit           clip_q;
  pose_t        pose_fifo[$];
  int           errors;

  assign errors_o  = errors;
  assign pending_o = pose_fifo.size();

  function automatic longint sx(input logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint clamp32(input longint v, input bit flag);
    if (v > I32_MAX) begin
      if (flag) clip_q = 1'b1;
      return I32_MAX;
    end
    if (v < I32_MIN) begin
      if (flag) clip_q = 1'b1;
      return I32_MIN;
    end
    return v;
  endfunction

  // rotation-mode cordic, cos and sin in q2.30
  function automatic void sin_cos(input logic [31:0] ang, output longint c, output longint s);
    longint a, x, y, nx;
    bit     flip;
    a    = sx(ang);
    x    = longint'(CORDIC_GAIN);
    y    = 0;
    flip = 1'b0;
    if (a > longint'(QUARTER_TURN)) begin
      a -= longint'(HALF_TURN);
      flip = 1'b1;
    end else if (a < -longint'(QUARTER_TURN)) begin
      a += longint'(HALF_TURN);
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_ITERATIONS && i < 32; i++) begin
      if (a >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        a -= longint'(atan_turn(i[4:0]));
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        a += longint'(atan_turn(i[4:0]));
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // q16.16 rate over one step as a binary angle
  function automatic logic [31:0] rate_turn(input longint rate);
    logic [63:0] p, q;
    p = rate * longint'({1'b0, step_q});
    q = p * INV_TWO_PI;
    return q[63:32];
  endfunction

  function automatic logic [31:0] advance(input logic [31:0] pos, input longint vel);
    longint d;
    d = (vel * longint'({1'b0, step_q})) >>> 16;
    return 32'(clamp32(sx(pos) + d, 1'b1));
  endfunction

  function automatic void move_body(input longint vx, input longint vy);
    longint c, s;
    sin_cos(ph_q, c, s);
    px_q = advance(px_q, (vx * c - vy * s) >>> 30);
    py_q = advance(py_q, (vx * s + vy * c) >>> 30);
  endfunction

  function automatic void move_arc(input longint v, input longint omega);
    longint      r, c0, s0, c1, s1;
    logic [31:0] h1;
    if (omega == 0) begin
      move_body(v, 0);
      return;
    end
    r  = clamp32((v * 65536) / omega, 1'b1);
    h1 = ph_q + rate_turn(omega);
    sin_cos(ph_q, c0, s0);
    sin_cos(h1, c1, s1);
    px_q = 32'(clamp32(sx(px_q) + ((r * (s1 - s0)) >>> 30), 1'b1));
    py_q = 32'(clamp32(sx(py_q) + ((r * (c0 - c1)) >>> 30), 1'b1));
    ph_q = h1;
  endfunction

  function automatic void move_acker(input longint v, input longint steer);
    longint      c, s, tanq, len, omega;
    logic [63:0] prod;
    if (steer == 0) begin
      move_body(v, 0);
      return;
    end
    prod = 64'(steer) * INV_TWO_PI;
    sin_cos(prod[47:16], c, s);
    // tan saturates silently, a zero cosine goes to the rail
    if (c == 0) tanq = (s >= 0) ? I32_MAX : I32_MIN;
    else tanq = clamp32((s * 65536) / c, 1'b0);
    len   = (wbase_q != 0) ? longint'({1'b0, wbase_q}) : 1;
    omega = clamp32((v * tanq) / len, 1'b0);
    move_arc(v, omega);
  endfunction

  function automatic pose_t next_pose(input logic [31:0] a, input logic [31:0] b,
                                      input logic [31:0] w);
    pose_t r;
    clip_q = 1'b0;
    case (model_q)
      DM_DIFF:  move_arc(sx(a), sx(b));
      DM_OMNI:  move_body(sx(a), sx(b));
      DM_OMNI_ROT: begin
        move_body(sx(a), sx(b));
        ph_q = ph_q + rate_turn(sx(w));
      end
      default:  move_acker(sx(a), sx(b));
    endcase
    r.x   = px_q;
    r.y   = py_q;
    r.h   = ph_q;
    r.sat = clip_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pose_t e;
    if (!rst_ni) begin
      model_q = DM_DIFF;
      step_q  = 17'd655;
      wbase_q = 31'd32768;
      px_q    = '0;
      py_q    = '0;
      ph_q    = '0;
      errors  = 0;
      pose_fifo.delete();
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[4:2]))
          RI_MODEL:   model_q = drive_model_e'(pwdata[1:0]);
          RI_STEP:    step_q  = pwdata[16:0];
          RI_WBASE:   wbase_q = pwdata[30:0];
          RI_START_X: px_q    = pwdata;
          RI_START_Y: py_q    = pwdata;
          RI_START_H: ph_q    = pwdata;
          default: ;
        endcase
      end
      if (pose.valid && pose.ready) begin
        if (pose_fifo.size() == 0) begin
          errors++;
          if (errors <= 10) $display("pose result with no request pending");
        end else begin
          e = pose_fifo.pop_front();
          if (pose.pose_x_out !== e.x || pose.pose_y_out !== e.y ||
              pose.heading_out !== e.h || pose.saturated !== e.sat) begin
            errors++;
            if (errors <= 10)
              $display("pose mismatch: exp x=%h y=%h h=%h sat=%b  got x=%h y=%h h=%h sat=%b",
                       e.x, e.y, e.h, e.sat, pose.pose_x_out, pose.pose_y_out,
                       pose.heading_out, pose.saturated);
          end
        end
      end
      if (cmd.valid && cmd.ready)
        pose_fifo.push_back(next_pose(cmd.first_cmd, cmd.second_cmd, cmd.third_cmd));
    end
  end

endmodule

// ===== verif/tb_mobile_base_pose_integrator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mobile_base_pose_integrator
// pose integrator testbench: directed corners, then random velocity commands
// in phases over all drive models and register settings, with bursty command
// traffic and a stalling pose receiver; a checker beside the block forecasts
// and compares every pose
// ----------------------------------------------------------------------------
module tb_mobile_base_pose_integrator;
  import mbpi_pkg::*;

  localparam logic [31:0] I_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] I_MIN = 32'h8000_0000;
  localparam logic [31:0] NEAR_RIGHT = 32'd102944;   // pi/2 in q16.16
  localparam int          NUM_PHASES = 10;
  localparam int          PHASE_CMDS = 150;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_cnt, pending_cnt;
  int          cmds_sent, burst_left;
  bit          hold_req;

  mbpi_cmd_if  cmd_if ();
  mbpi_pose_if pose_if ();

  mobile_base_pose_integrator DUT (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cmd_i(cmd_if), .pose_o(pose_if)
  );

  mbpi_pose_checker u_checker (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .cmd(cmd_if), .pose(pose_if), .errors_o(fail_cnt), .pending_o(pending_cnt)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    cmd_if.valid      = 1'b0;
    cmd_if.first_cmd  = '0;
    cmd_if.second_cmd = '0;
    cmd_if.third_cmd  = '0;
    pose_if.ready     = 1'b0;
    hold_req          = 1'b0;
  end

  // pose receiver: steps through randomly chosen stall patterns, plus one long hold
  initial begin
    int mode;
    mode = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        pose_if.ready <= 1'b0;
        repeat (4000) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        for (int k = 0; k < 64; k++) begin
          case (mode)
            0: pose_if.ready <= 1'b1;
            1: pose_if.ready <= 1'($urandom_range(0, 1));
            2: pose_if.ready <= ($urandom_range(0, 3) == 0);
            default: pose_if.ready <= k[2];
          endcase
          if (k != 63) @(posedge clk_i);
        end
        mode = $urandom_range(0, 3);
      end
    end
  end

  // register write, setup then access cycle; called at a rising edge
  task automatic reg_write(input reg_idx_e idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // one command request, held until taken; bursts end in a random gap
  task automatic send_cmd(input logic [31:0] a, input logic [31:0] b, input logic [31:0] w);
    int gap;
    cmd_if.valid      <= 1'b1;
    cmd_if.first_cmd  <= a;
    cmd_if.second_cmd <= b;
    cmd_if.third_cmd  <= w;
    @(negedge clk_i);
    while (!cmd_if.ready) @(negedge clk_i);
    @(posedge clk_i);
    cmds_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        cmd_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // stop offering and wait for every pose to come back
  task automatic drain();
    cmd_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_cmd();
    case ($urandom_range(0, 6))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? I_MAX : I_MIN;
      2: return 32'(int'($urandom_range(0, 16)) - 8);
      3: return 32'(int'($urandom_range(0, 524288)) - 262144);
      4: return 32'(int'($urandom_range(0, 2097152)) - 1048576);
      5: return '0;
      default: return 32'(int'($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  function automatic logic [31:0] rand_step();
    case ($urandom_range(0, 4))
      0: return 32'd1;
      1: return 32'd65536;
      2: return 32'd655;
      3: return $urandom_range(1, 65536);
      default: return $urandom_range(1, 4096);
    endcase
  endfunction

  function automatic logic [31:0] rand_wbase();
    case ($urandom_range(0, 3))
      0: return 32'd1;
      1: return 32'h7FFF_FFFF;
      2: return 32'd32768;
      default: return $urandom_range(1, 32'h7FFF_FFFF);
    endcase
  endfunction

  // stimulus
  initial begin
    drive_model_e m;
    cmds_sent  = 0;
    burst_left = 1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // differential: straight line, arc, radius overflow
    reg_write(RI_MODEL, 32'(DM_DIFF));
    reg_write(RI_STEP, 32'd655);
    reg_write(RI_WBASE, 32'd32768);
    reg_write(RI_START_X, 32'd0);
    reg_write(RI_START_Y, 32'd0);
    reg_write(RI_START_H, 32'd0);
    send_cmd(0, 0, 0);
    send_cmd(I_MAX, 0, 0);
    send_cmd(32'd65536, 32'd65536, 0);
    send_cmd(I_MAX, 32'd1, 0);
    send_cmd(I_MIN, 32'hFFFF_FFFF, 0);
    send_cmd(32'hFFFF_0000, I_MIN, 0);
    // position pinned at the positive rail
    drain();
    reg_write(RI_STEP, 32'd65536);
    reg_write(RI_START_X, I_MAX - 10);
    send_cmd(I_MAX, 0, 0);
    // omni, full-scale body speeds
    drain();
    reg_write(RI_MODEL, 32'(DM_OMNI));
    send_cmd(I_MAX, I_MIN, 0);
    send_cmd(I_MIN, I_MAX, 0);
    // omni with turn rate, heading wraps past a full turn
    drain();
    reg_write(RI_MODEL, 32'(DM_OMNI_ROT));
    reg_write(RI_START_H, 32'hFFFF_FFF0);
    send_cmd(32'd65536, 32'd65536, I_MAX);
    send_cmd(0, 0, I_MIN);
    // ackermann: zero steer, steer near a right angle, wheelbase extremes
    drain();
    reg_write(RI_MODEL, 32'(DM_ACKER));
    reg_write(RI_WBASE, 32'd1);
    send_cmd(32'd65536, 0, 0);
    send_cmd(32'd65536, NEAR_RIGHT, 0);
    send_cmd(I_MAX, -NEAR_RIGHT, 0);
    drain();
    reg_write(RI_WBASE, 32'h7FFF_FFFF);
    send_cmd(I_MIN, I_MAX, 0);
    send_cmd(32'd65536, I_MIN, 0);
    drain();
    reg_write(RI_STEP, 32'd1);
    send_cmd(32'd1, 32'd65536, 0);
    drain();

    // random phases, one drive model each, registers reshuffled in between
    for (int p = 0; p < NUM_PHASES; p++) begin
      m = drive_model_e'(p[1:0]);
      reg_write(RI_MODEL, 32'(m));
      reg_write(RI_STEP, rand_step());
      reg_write(RI_WBASE, rand_wbase());
      if ($urandom_range(0, 1)) begin
        reg_write(RI_START_X, $urandom_range(0, 3) == 0 ? I_MIN : $urandom);
        reg_write(RI_START_Y, $urandom_range(0, 3) == 0 ? I_MAX : $urandom);
        reg_write(RI_START_H, $urandom);
      end
      // long receiver hold once, so the block backs up onto its input
      if (p == 3) hold_req = 1'b1;
      for (int n = 0; n < PHASE_CMDS; n++)
        send_cmd(rand_cmd(), rand_cmd(), rand_cmd());
      drain();
    end

    repeat (1000) @(posedge clk_i);
    $display("covered %0d pose commands: directed corners and %0d random phases", cmds_sent,
             NUM_PHASES);
    $display("all four drive models, step and wheelbase extremes, start pose reloads");
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #40ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/mbpi_pkg.sv
rtl/core/mbpi_cmd_if.sv
rtl/core/mbpi_pose_if.sv
rtl/core/mbpi_cordic.sv
rtl/core/mbpi_mul.sv
rtl/core/mbpi_div.sv
rtl/core/mobile_base_pose_integrator.sv
verif/mbpi_pose_checker.sv
verif/tb_mobile_base_pose_integrator.sv
